// ===== rtl/core/nrsr_pkg.sv =====
// Package: shared types and constants of the nested record subtree resolver.
`default_nettype none
package nrsr_pkg;
  localparam int unsigned IN_W = 288;
  localparam int unsigned OUT_W = 104;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_ROOT  = 1'b1;

  localparam logic CMD_ROOT  = 1'b0;
  localparam logic CMD_CHILD = 1'b1;

  localparam logic [2:0] ST_ACCEPT  = 3'd0;
  localparam logic [2:0] ST_SKIP    = 3'd1;
  localparam logic [2:0] ST_RDERR   = 3'd2;
  localparam logic [2:0] ST_OVERFL  = 3'd3;
  localparam logic [2:0] ST_IDLE    = 3'd4;

  localparam logic [2:0] RS_NONE    = 3'd0;
  localparam logic [2:0] RS_LIMIT   = 3'd1;
  localparam logic [2:0] RS_PREFIX  = 3'd2;
  localparam logic [2:0] RS_FLAG8   = 3'd3;
  localparam logic [2:0] RS_TYPE0   = 3'd4;
  localparam logic [2:0] RS_SHORT   = 3'd5;

  localparam logic [31:0] WORD_LIMIT  = 32'd65535;
  localparam logic [31:0] MIN_WORDS   = 32'd16;
  localparam logic [15:0] LEG_MAX     = 16'd2500;
  localparam logic [31:0] LEG_BASE    = 32'd172;

  // classified item passed from front to back
  typedef struct packed {
    logic        cmd;
    logic [2:0]  status;
    logic [2:0]  reason;
    logic        zero_prefix;
    logic        comp;
    logic [31:0] count;
  } cls_t;
endpackage
`default_nettype wire

// ===== rtl/core/nrsr_front.sv =====
// Front end: accepts records, filters and classifies them into a short queue.
`default_nettype none
module nrsr_front
  import nrsr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            in_tuser,
  input  wire logic [IN_W-1:0] in_tdata,
  output logic                 q_valid,
  output cls_t                 q_data,
  input  wire logic            q_pop
);
  logic [31:0] prefix, words, base, c36, c108, marker, pair;
  logic [15:0] etype, flags, half, entries;
  cls_t        cls;
  cls_t        q_r [2];
  logic [1:0]  cnt_r;
  logic        rd_r, wr_r;
  logic        push;
  logic        ext, legacy;
  logic [31:0] word;

  assign prefix  = in_tdata[31:0];
  assign words   = in_tdata[63:32];
  assign base    = in_tdata[95:64];
  assign etype   = in_tdata[111:96];
  assign flags   = in_tdata[127:112];
  assign c36     = in_tdata[159:128];
  assign c108    = in_tdata[191:160];
  assign half    = in_tdata[207:192];
  assign marker  = in_tdata[239:208];
  assign pair    = in_tdata[271:240];
  assign entries = in_tdata[287:272];

  always_comb begin
    cls.cmd = in_tuser;
    cls.zero_prefix = (prefix == 32'd0);
    cls.status = ST_ACCEPT;
    cls.reason = RS_NONE;
    if (words > WORD_LIMIT) begin
      cls.status = ST_RDERR;
      cls.reason = RS_LIMIT;
    end else if (prefix != 32'd0) begin
      cls.status = ST_SKIP;
      cls.reason = RS_PREFIX;
    end else if (flags[3]) begin
      cls.status = ST_SKIP;
      cls.reason = RS_FLAG8;
    end else if (etype == 16'd0) begin
      cls.status = ST_SKIP;
      cls.reason = RS_TYPE0;
    end else if (words < MIN_WORDS) begin
      cls.status = ST_SKIP;
      cls.reason = RS_SHORT;
    end
    ext = flags[5];
    cls.comp = (etype >= 16'd10 && etype <= 16'd32) ||
               ((etype < 16'd33 || etype > 16'd63) && flags[6]);
    word = ext ? c108 : c36;
    legacy = (marker == 32'd0) && (pair == 32'd0) && (entries <= LEG_MAX) &&
             (base == LEG_BASE + {13'd0, entries, 3'd0});
    if (etype == 16'd13)
      cls.count = (legacy && ext) ? {16'd0, half} : word;
    else
      cls.count = cls.comp ? word : 32'd0;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= cls;
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/nrsr_back.sv =====
// Back end: walks the nesting stack and builds one result per record.
`default_nettype none
module nrsr_back
  import nrsr_pkg::*;
#(
  parameter int unsigned MAX_DEPTH  = 16,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       start_count,
  input  wire logic [15:0]       root_index,
  input  wire logic              q_valid,
  input  cls_t                   q_data,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic                   out_tlast,
  output logic [OUT_W-1:0]       out_tdata
);
  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_POP, S_OUT} state_t;

  state_t      state_r;
  logic        active_r;
  logic [31:0] ctr_r;
  logic [15:0] off_r;
  logic [LW-1:0] lvl_r;
  logic [31:0] ends_r [MAX_DEPTH];
  logic [15:0] pars_r [MAX_DEPTH];
  logic [2:0]  st_r, rs_r;
  logic [15:0] rec_r, par_r;
  logic        comp_r, mem_r, done_r;
  logic [31:0] cnt_r;
  logic [OUT_W-1:0] obuf_r;
  logic        last_r;
  logic        ovld_r;

  logic [15:0] idx_mask, off1, rec_c, rec0;
  logic [31:0] ctr1, root_tgt, child_tgt;
  logic [AW-1:0] top_a, lvl_a;
  logic        acc, rderr, root_push, child_push, child_ovf, out_load;

  assign idx_mask = (INDEX_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << INDEX_BITS) - 17'd1);
  assign off1 = off_r + 16'd1;
  assign rec_c = (root_index + off1) & idx_mask;
  assign rec0 = root_index & idx_mask;
  assign top_a = AW'(lvl_r - LW'(1));
  assign lvl_a = AW'(lvl_r);
  assign ctr1 = ctr_r + {31'd0, q_data.zero_prefix};

  assign acc = (q_data.status == ST_ACCEPT);
  assign rderr = (q_data.status == ST_RDERR);
  assign root_tgt = start_count + q_data.count;
  assign child_tgt = ctr1 + q_data.count;
  assign root_push = acc && (start_count < root_tgt);
  assign child_push = acc && q_data.comp && (ctr1 < child_tgt);
  assign child_ovf = child_push && (lvl_r >= LW'(MAX_DEPTH));

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign out_load = (state_r == S_OUT) && (!ovld_r || out_tready);
  assign out_tvalid = ovld_r;
  assign out_tdata = obuf_r;
  assign out_tlast = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      active_r <= 1'b0;
      ctr_r <= 32'd0;
      off_r <= 16'd0;
      lvl_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (out_load) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.cmd == CMD_ROOT) begin
              st_r <= q_data.status;
              rs_r <= q_data.reason;
              rec_r <= rec0;
              par_r <= rec0;
              comp_r <= acc && q_data.comp;
              mem_r <= 1'b0;
              cnt_r <= acc ? q_data.count : 32'd0;
              done_r <= !root_push;
              off_r <= 16'd0;
              ctr_r <= start_count;
              lvl_r <= root_push ? LW'(1) : '0;
              active_r <= root_push;
              if (root_push) begin
                ends_r[0] <= root_tgt;
                pars_r[0] <= rec0;
              end
              state_r <= S_OUT;
            end else if (!active_r) begin
              st_r <= ST_IDLE;
              rs_r <= RS_NONE;
              rec_r <= 16'd0;
              par_r <= 16'd0;
              comp_r <= 1'b0;
              mem_r <= 1'b0;
              cnt_r <= 32'd0;
              done_r <= 1'b0;
              state_r <= S_OUT;
            end else begin
              st_r <= child_ovf ? ST_OVERFL : q_data.status;
              rs_r <= q_data.reason;
              off_r <= off1;
              rec_r <= rec_c;
              par_r <= pars_r[top_a];
              comp_r <= acc && q_data.comp;
              mem_r <= acc && (lvl_r == LW'(1));
              cnt_r <= acc ? q_data.count : 32'd0;
              done_r <= rderr || child_ovf;
              if (!rderr) ctr_r <= ctr1;
              if (rderr || child_ovf) begin
                active_r <= 1'b0;
                lvl_r <= '0;
              end else if (child_push) begin
                ends_r[lvl_a] <= child_tgt;
                pars_r[lvl_a] <= rec_c;
                lvl_r <= lvl_r + LW'(1);
              end
              state_r <= (acc && !child_ovf) ? S_POP : S_OUT;
            end
          end
        end
        S_POP: begin
          if (lvl_r != '0 && ctr_r >= ends_r[top_a]) begin
            lvl_r <= lvl_r - LW'(1);
          end else begin
            if (lvl_r == '0) begin
              done_r <= 1'b1;
              active_r <= 1'b0;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            obuf_r <= {ctr_r, cnt_r, mem_r, comp_r, par_r, rec_r, rs_r, st_r};
            last_r <= done_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/nested_record_subtree_resolver_core.sv =====
// Top level: nested record subtree resolver core.
// Path: queue, then back end S_IDLE; a root, idle or skipped child, read error or
// overflow goes on to S_OUT, an accepted child to S_POP until no ended level is left.
// S_OUT loads the result register once it is free; only then is a new record popped, so the
// back end's stack walk sets the rate; a 2-entry queue decouples input.
// Synchronous active-low reset clears counters, level, queue and result valid.
`default_nettype none
module nested_record_subtree_resolver_core
  import nrsr_pkg::*;
#(
  parameter int unsigned MAX_DEPTH  = 16,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [31:0]      cfg_wdata,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_tuser,  // command
  // prefix_word, record_words, base_cnt, elem_type, elem_flags, count_at_36,
  // count_at_108, half_count_at_64, legacy_marker, legacy_pair, legacy_entries
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic                  out_tlast, // done_res
  // status, reason, record_index, parent_index, is_compound, is_member,
  // desc_cnt, counter_now
  output logic [OUT_W-1:0]      out_tdata
);
  logic [31:0] start_r;
  logic [15:0] root_r;
  logic        q_valid, q_pop;
  cls_t        q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 32'd0;
      root_r <= 16'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_START) start_r <= cfg_wdata;
      else root_r <= cfg_wdata[15:0];
    end
  end

  nrsr_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .q_valid, .q_data, .q_pop
  );

  nrsr_back #(.MAX_DEPTH(MAX_DEPTH), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk, .rst_n, .start_count(start_r), .root_index(root_r),
    .q_valid, .q_data, .q_pop, .out_tvalid, .out_tready, .out_tlast, .out_tdata
  );
endmodule
`default_nettype wire

// ===== test/tb_nested_record_subtree_resolver_core.sv =====
// Testbench: drives record headers into the subtree resolver and checks every result.
`timescale 1ns / 1ps
`default_nettype none
module tb_nested_record_subtree_resolver_core;
  import nrsr_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    logic        cmd;
    logic [31:0] prefix, words, base;
    logic [15:0] etype, flags;
    logic [31:0] c36, c108;
    logic [15:0] half;
    logic [31:0] marker, pair;
    logic [15:0] entries;
  } rec_t;

  typedef struct {
    logic [2:0]  status, reason;
    logic [15:0] rec, par;
    logic        comp, member;
    logic [31:0] count, counter;
    logic        done;
  } res_t;

  class resolver_scoreboard;
    res_t pending[$];
    int errors;
    logic [31:0] start_cnt;
    logic [15:0] root_idx;
    logic        open;
    logic [31:0] counter;
    logic [15:0] offset;
    int          level;
    logic [31:0] ends[DEPTH];
    logic [15:0] parents[DEPTH];

    function new();
      errors = 0; start_cnt = 0; root_idx = 0; open = 0; counter = 0;
      offset = 0; level = 0;
    endfunction

    function void screen(rec_t r, output logic [2:0] st, output logic [2:0] rs);
      st = ST_SKIP;
      if (r.words > WORD_LIMIT) begin st = ST_RDERR; rs = RS_LIMIT; end
      else if (r.prefix != 0) rs = RS_PREFIX;
      else if (r.flags[3]) rs = RS_FLAG8;
      else if (r.etype == 0) rs = RS_TYPE0;
      else if (r.words < MIN_WORDS) rs = RS_SHORT;
      else begin st = ST_ACCEPT; rs = RS_NONE; end
    endfunction

    function logic classify(rec_t r, output logic [31:0] cnt);
      logic ext, comp, legacy;
      logic [31:0] w;
      ext = r.flags[5];
      comp = (r.etype >= 10 && r.etype <= 32) ||
             ((r.etype < 33 || r.etype > 63) && r.flags[6]);
      w = ext ? r.c108 : r.c36;
      if (r.etype == 13) begin
        legacy = r.marker == 0 && r.pair == 0 && r.entries <= LEG_MAX &&
                 r.base == LEG_BASE + 32'd8 * r.entries;
        cnt = (legacy && ext) ? {16'd0, r.half} : w;
      end else cnt = comp ? w : 32'd0;
      return comp;
    endfunction

    function void note_input(rec_t r);
      res_t e;
      logic [31:0] tgt;
      e = '{default: 0};
      if (r.cmd == CMD_ROOT) begin
        open = 0; level = 0; offset = 0; counter = start_cnt;
        e.rec = root_idx; e.par = root_idx;
        screen(r, e.status, e.reason);
        if (e.status != ST_ACCEPT) e.done = 1;
        else begin
          e.comp = classify(r, e.count);
          tgt = counter + e.count;
          if (counter < tgt) begin
            ends[0] = tgt; parents[0] = e.rec; level = 1; open = 1;
          end else e.done = 1;
        end
      end else if (!open) e.status = ST_IDLE;
      else begin
        offset++;
        e.rec = root_idx + offset;
        e.par = parents[level-1];
        screen(r, e.status, e.reason);
        if (e.status == ST_RDERR) e.done = 1;
        else begin
          if (r.prefix == 0) counter++;
          if (e.status == ST_ACCEPT) begin
            e.comp = classify(r, e.count);
            e.member = (level == 1);
            tgt = counter + e.count;
            if (e.comp && counter < tgt) begin
              if (level >= DEPTH) begin e.status = ST_OVERFL; e.done = 1; end
              else begin ends[level] = tgt; parents[level] = e.rec; level++; end
            end
            if (!e.done) begin
              while (level > 0 && counter >= ends[level-1]) level--;
              if (level == 0) e.done = 1;
            end
          end
        end
        if (e.done) begin open = 0; level = 0; end
      end
      e.counter = counter;
      pending.insert(pending.size(), e);
    endfunction

    function void check_result(logic [OUT_W-1:0] d, logic last);
      res_t e;
      logic [OUT_W-1:0] x;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending.pop_front();
      x = {e.counter, e.count, e.member, e.comp, e.par, e.rec, e.reason, e.status};
      if (x !== d || e.done !== last) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: exp %h last %b, got %h last %b", x, e.done, d, last);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0, cfg_index = 0;
  logic [31:0] cfg_wdata = 0;
  logic in_tvalid = 0, in_tuser = 0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tready, out_tvalid, out_tlast;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  resolver_scoreboard sb;

  always #6 clk = ~clk;

  nested_record_subtree_resolver_core u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_tvalid, .in_tready,
    .in_tuser, .in_tdata, .out_tvalid, .out_tready, .out_tlast, .out_tdata);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  initial begin
    forever begin
      @(posedge clk);
      out_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send(rec_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= r.cmd;
    in_tdata <= {r.entries, r.pair, r.marker, r.half, r.c108, r.c36, r.flags, r.etype,
                 r.base, r.words, r.prefix};
    do @(posedge clk); while (!in_tready);
    sb.note_input(r);
  endtask

  task automatic drain();
    int i;
    in_tvalid <= 0;
    for (i = 0; i < 20000 && sb.pending.size() != 0; i++) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_START) sb.start_cnt = v; else sb.root_idx = v[15:0];
  endtask

  function automatic rec_t good_rec(logic cmd, logic comp, logic [31:0] cnt);
    rec_t r;
    r.cmd = cmd; r.prefix = 0; r.words = $urandom_range(16, 65535);
    r.base = $urandom;
    r.etype = 16'(comp ? $urandom_range(10, 32) : $urandom_range(64, 200));
    r.flags = 16'($urandom) & 16'hFF97;
    if (!comp) r.flags[6] = 0;
    r.c36 = cnt; r.c108 = cnt; r.half = 16'($urandom); r.marker = $urandom;
    r.pair = $urandom; r.entries = 16'($urandom);
    if (r.etype == 13) r.flags[5] = 0;
    return r;
  endfunction

  function automatic rec_t noise_rec();
    rec_t r;
    r.cmd = 1'($urandom); r.prefix = ($urandom_range(0, 2) == 0) ? $urandom : 0;
    r.words = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 70000);
    r.base = $urandom;
    r.etype = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70));
    r.flags = 16'($urandom); r.c36 = $urandom_range(0, 6); r.c108 = $urandom;
    r.half = 16'($urandom); r.marker = $urandom_range(0, 1) ? 0 : $urandom;
    r.pair = $urandom_range(0, 1) ? 0 : $urandom;
    r.entries = 16'($urandom_range(0, 2600));
    if ($urandom_range(0, 1)) r.base = 32'd172 + 32'd8 * r.entries;
    return r;
  endfunction

  task automatic run_tree();
    int n, i;
    n = $urandom_range(3, 20);
    send(good_rec(CMD_ROOT, 1, n));
    for (i = 0; i < n + 2; i++) begin
      if ($urandom_range(0, 9) == 0) send(noise_rec());
      else if ($urandom_range(0, 3) == 0) send(good_rec(CMD_CHILD, 1, $urandom_range(1, 4)));
      else send(good_rec(CMD_CHILD, 0, 0));
    end
  endtask

  initial begin
    rec_t r;
    int i;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_cfg(CFG_START, 32'hFFFF_FFF0);
    write_cfg(CFG_ROOT, 32'h0000_FFFE);
    // directed: filters, legacy type 13, wrap, overflow, idle child
    r = good_rec(CMD_CHILD, 0, 0); send(r);
    r = good_rec(CMD_ROOT, 1, 0); r.words = 32'hFFFF_FFFF; send(r);
    r = good_rec(CMD_ROOT, 1, 5); r.prefix = 32'hFFFF_FFFF; send(r);
    r = good_rec(CMD_ROOT, 1, 5); r.flags[3] = 1; send(r);
    r = good_rec(CMD_ROOT, 1, 5); r.etype = 0; send(r);
    r = good_rec(CMD_ROOT, 1, 5); r.words = 15; send(r);
    r = good_rec(CMD_ROOT, 1, 0); send(r);
    r = good_rec(CMD_ROOT, 1, 32'h20); send(r);
    r = good_rec(CMD_CHILD, 0, 0); r.etype = 13; r.flags = 16'hFFF7; r.marker = 0;
    r.pair = 0; r.entries = 2500; r.base = 32'd172 + 32'd8 * 32'd2500; r.half = 16'hFFFF;
    send(r);
    r = good_rec(CMD_CHILD, 0, 0); r.etype = 16'hFFFF; r.flags = 16'h0040;
    r.c36 = 3; send(r);
    drain();
    write_cfg(CFG_START, 0);
    write_cfg(CFG_ROOT, 0);
    send(good_rec(CMD_ROOT, 1, 1000));
    for (i = 0; i < 17; i++) send(good_rec(CMD_CHILD, 1, 500 - i));
    r = good_rec(CMD_CHILD, 0, 0); r.words = 70000; send(r);
    drain();
    for (i = 0; i < 30; i++) begin
      if (i % 8 == 0) begin
        drain();
        write_cfg(CFG_START, (i % 16 == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 9));
        write_cfg(CFG_ROOT, $urandom);
      end
      run_tree();
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
